@@ sv/pwaa_pkg.sv @@
// package for the probe window area aggregator
// widths, register indexes and sizing defaults; no dependencies
package pwaa_pkg;
  localparam int unsigned NumProbesDef    = 8;
  localparam int unsigned NumAreasDef     = 8;
  localparam int unsigned NumMetricsDef   = 4;
  localparam int unsigned HistoryDepthDef = 10;

  localparam int unsigned ValW  = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [3:0] NoArea = 4'd15;

  localparam logic [CfgIdxW-1:0] RegAggMode  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegAreaMap  = 1'b1;

  localparam logic ReqSample = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [2:0] probe_index;
    logic [1:0] metric_index;
    logic signed [31:0] sample_value;
    logic [2:0] area_index;
    logic [3:0] window_len;
  } req_t;

  typedef struct packed {
    logic signed [31:0] area_min;
    logic signed [31:0] area_max;
    logic               stats_valid;
    logic signed [31:0] agg_value;
    logic               agg_valid;
  } rsp_t;
endpackage

@@ sv/pwaa_req_if.sv @@
// request channel interface: valid, ready and one request beat
// depends on pwaa_pkg
interface pwaa_req_if;
  logic             valid;
  logic             ready;
  pwaa_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/pwaa_rsp_if.sv @@
// response channel interface: valid, ready and one result beat
// depends on pwaa_pkg
interface pwaa_rsp_if;
  logic             valid;
  logic             ready;
  pwaa_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/pwaa_ram.sv @@
// generic simple dual port synchronous ram, one write and one registered read port
// no dependencies
module pwaa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ sv/pwaa_div.sv @@
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// no dependencies
module pwaa_div #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [DenW-1:0]        den_i,
  output logic                   done_o,
  output logic signed [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW+1:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      neg_d  = num_i[NumW-1];
      quo_d  = num_i[NumW-1] ? (~num_i + 1'b1) : num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[NumW-1]} - {2'b00, den_q};
      if (!trial[DenW+1]) begin
        rem_d = trial[DenW:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DenW-1:0], quo_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? $signed(~quo_q + 1'b1) : $signed(quo_q);
endmodule

@@ sv/probe_window_area_aggregator.sv @@
// top level of the probe window area aggregator
// depends on pwaa_pkg, pwaa_req_if, pwaa_rsp_if, pwaa_ram, pwaa_div
// a sample reads the area min/max ram, then writes history and min/max; a query walks
//   the probes, reads each member's used values through the single history read port and
//   divides their sum in the bit-serial divider; mean mode ends with one more divide
// throughput: one request at a time, ready again in the cycle after the result beat
// reset: asynchronous, clears counts, heads and stats-valid bits in flip-flops;
//   ram contents stay undefined and are never used before they are written
module probe_window_area_aggregator #(
  parameter int unsigned NumProbes    = pwaa_pkg::NumProbesDef,
  parameter int unsigned NumAreas     = pwaa_pkg::NumAreasDef,
  parameter int unsigned NumMetrics   = pwaa_pkg::NumMetricsDef,
  parameter int unsigned HistoryDepth = pwaa_pkg::HistoryDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwaa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  pwaa_req_if.sink                      req,
  pwaa_rsp_if.source                    rsp
);
  localparam int unsigned Series   = NumProbes * NumMetrics;
  localparam int unsigned Slots    = NumAreas * NumMetrics;
  localparam int unsigned HistN    = Series * HistoryDepth;
  localparam int unsigned HAddrW   = $clog2(HistN);
  localparam int unsigned SlotW    = $clog2(Slots);
  localparam int unsigned SumW     = 40;
  localparam int unsigned TotW     = 36;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StSRead  = 9'b000000010,
    StSWrite = 9'b000000100,
    StQProbe = 9'b000001000,
    StQRead  = 9'b000010000,
    StQDiv   = 9'b000100000,
    StQNext  = 9'b001000000,
    StQFinal = 9'b010000000,
    StOut    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic agg_mode_q;
  logic [31:0] area_map_q;
  logic [3:0] cnt_q [Series];
  logic [3:0] head_q [Series];
  logic [Slots-1:0] init_q;

  pwaa_pkg::req_t req_q;
  pwaa_pkg::rsp_t rsp_q, rsp_d;
  logic [3:0] probe_q, probe_d;
  logic [3:0] used_q, used_d, left_q, left_d;
  logic [3:0] pos_q, pos_d;
  logic [3:0] nprb_q, nprb_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [TotW-1:0] tot_q, tot_d;
  logic signed [31:0] best_q, best_d;
  logic rd_pend_q, rd_pend_d;
  logic fdiv_q, fdiv_d;

  // ram ports
  logic h_we, s_we;
  logic [HAddrW-1:0] h_waddr, h_raddr;
  logic [31:0] h_rdata, min_rdata, max_rdata, min_wdata, max_wdata;
  logic [63:0] mm_rdata;
  logic [SlotW-1:0] s_addr;

  logic div_start, div_done;
  logic signed [SumW-1:0] div_num, div_quo;
  logic [3:0] div_den;

  pwaa_ram #(.Width(32), .Depth(HistN)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(req_q.sample_value),
    .raddr_i(h_raddr), .rdata_o(h_rdata));
  pwaa_ram #(.Width(64), .Depth(Slots)) u_minmax (
    .clk_i, .we_i(s_we), .waddr_i(s_addr), .wdata_i({max_wdata, min_wdata}),
    .raddr_i(s_addr), .rdata_o(mm_rdata));
  pwaa_div #(.NumW(SumW), .DenW(4)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo));

  assign min_rdata = mm_rdata[31:0];
  assign max_rdata = mm_rdata[63:32];

  function automatic logic [3:0] area_of(logic [31:0] map, logic [3:0] p);
    logic [3:0] a;
    a = map[p[2:0]*4 +: 4];
    if (a == pwaa_pkg::NoArea || 32'(a) >= NumAreas) return pwaa_pkg::NoArea;
    return a;
  endfunction

  // decoded request
  logic samp_ok, qry_ok, samp_area_ok;
  logic [3:0] samp_area;
  logic [$clog2(Series)-1:0] ser, qser;
  logic [SlotW-1:0] slot;
  logic [3:0] win;
  logic [3:0] cur_area;

  always_comb begin
    samp_ok = 32'(req_q.probe_index) < NumProbes &&
              32'(req_q.metric_index) < NumMetrics;
    qry_ok  = 32'(req_q.area_index) < NumAreas &&
              32'(req_q.metric_index) < NumMetrics;
    samp_area = area_of(area_map_q, {1'b0, req_q.probe_index});
    samp_area_ok = samp_area != pwaa_pkg::NoArea;
    ser  = ($clog2(Series))'(32'(req_q.probe_index) * NumMetrics
                            + 32'(req_q.metric_index));
    qser = ($clog2(Series))'(32'(probe_q) * NumMetrics + 32'(req_q.metric_index));
    slot = SlotW'(32'(samp_area) * NumMetrics + 32'(req_q.metric_index));
    win  = (req_q.window_len == 4'd0) ? 4'd1 :
           (32'(req_q.window_len) > HistoryDepth) ? 4'(HistoryDepth) :
           req_q.window_len;
    cur_area = area_of(area_map_q, probe_q);
  end

  assign req.ready = (state_q == StIdle);
  assign rsp.valid = (state_q == StOut);
  assign rsp.data  = rsp_q;

  assign s_addr = slot;
  assign h_waddr = HAddrW'(32'(ser) * HistoryDepth + 32'(head_q[ser]));
  assign h_raddr = HAddrW'(32'(qser) * HistoryDepth + 32'(pos_q));

  always_comb begin
    min_wdata = req_q.sample_value;
    max_wdata = req_q.sample_value;
    if (init_q[slot]) begin
      if ($signed(min_rdata) < req_q.sample_value) min_wdata = min_rdata;
      if ($signed(max_rdata) > req_q.sample_value) max_wdata = max_rdata;
    end
  end

  always_comb begin
    state_d = state_q;
    rsp_d = rsp_q;
    probe_d = probe_q; used_d = used_q; left_d = left_q; pos_d = pos_q;
    nprb_d = nprb_q; sum_d = sum_q; tot_d = tot_q; best_d = best_q;
    rd_pend_d = 1'b0; fdiv_d = fdiv_q;
    h_we = 1'b0; s_we = 1'b0;
    div_start = 1'b0; div_num = sum_q; div_den = used_q;
    case (state_q)
      StIdle: begin
        if (req.valid) begin
          rsp_d = '0;
          probe_d = '0; nprb_d = '0; tot_d = '0; best_d = '0; fdiv_d = 1'b0;
          state_d = (req.data.req_type == pwaa_pkg::ReqSample) ? StSRead : StQProbe;
        end
      end
      StSRead: state_d = samp_ok ? StSWrite : StOut;
      StSWrite: begin
        h_we = 1'b1;
        if (samp_area_ok) begin
          s_we = 1'b1;
          rsp_d.area_min = min_wdata;
          rsp_d.area_max = max_wdata;
          rsp_d.stats_valid = 1'b1;
        end
        state_d = StOut;
      end
      StQProbe: begin
        if (!qry_ok || 32'(probe_q) >= NumProbes) begin
          state_d = (qry_ok && nprb_q != 4'd0) ? StQFinal : StOut;
        end else if (cur_area != {1'b0, req_q.area_index} || cnt_q[qser] == 4'd0) begin
          probe_d = probe_q + 1'b1;
        end else begin
          used_d = (cnt_q[qser] > win) ? win : cnt_q[qser];
          left_d = used_d;
          pos_d = (head_q[qser] == 4'd0) ? 4'(HistoryDepth - 1) : head_q[qser] - 1'b1;
          sum_d = '0;
          state_d = StQRead;
        end
      end
      StQRead: begin
        if (rd_pend_q) begin
          sum_d = sum_q + SumW'($signed(h_rdata));
          if (left_q == 4'd0) begin
            state_d = StQDiv;
            div_start = 1'b1;
            div_num = sum_d;
          end
        end
        if (left_q != 4'd0) begin
          rd_pend_d = 1'b1;
          left_d = left_q - 1'b1;
          pos_d = (pos_q == 4'd0) ? 4'(HistoryDepth - 1) : pos_q - 1'b1;
        end
      end
      StQDiv: begin
        if (div_done) begin
          if (nprb_q == 4'd0 || $signed(div_quo[31:0]) > best_q) best_d = div_quo[31:0];
          tot_d = tot_q + TotW'($signed(div_quo[31:0]));
          nprb_d = nprb_q + 1'b1;
          probe_d = probe_q + 1'b1;
          state_d = StQProbe;
        end
      end
      StQFinal: begin
        if (!fdiv_q) begin
          if (agg_mode_q) begin
            rsp_d.agg_value = best_q;
            rsp_d.agg_valid = 1'b1;
            state_d = StOut;
          end else begin
            div_start = 1'b1;
            div_num = SumW'(tot_q);
            div_den = nprb_q;
            fdiv_d = 1'b1;
          end
        end else if (div_done) begin
          rsp_d.agg_value = div_quo[31:0];
          rsp_d.agg_valid = 1'b1;
          state_d = StOut;
        end
      end
      StOut: if (rsp.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // read address must be valid in the cycle before use; pos_q is advanced after issue
  // so the read issued at pos_q lands next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      agg_mode_q <= 1'b0;
      area_map_q <= '1;
      init_q <= '0;
      rd_pend_q <= 1'b0;
      for (int i = 0; i < Series; i++) begin
        cnt_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      rd_pend_q <= rd_pend_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pwaa_pkg::RegAggMode: agg_mode_q <= cfg_wdata_i[0];
          pwaa_pkg::RegAreaMap: area_map_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (h_we) begin
        head_q[ser] <= (32'(head_q[ser]) + 1 >= HistoryDepth) ? 4'd0 : head_q[ser] + 1'b1;
        if (32'(cnt_q[ser]) < HistoryDepth) cnt_q[ser] <= cnt_q[ser] + 1'b1;
      end
      if (s_we) init_q[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req.valid) req_q <= req.data;
    rsp_q <= rsp_d;
    probe_q <= probe_d; used_q <= used_d; left_q <= left_d; pos_q <= pos_d;
    nprb_q <= nprb_d; sum_q <= sum_d; tot_q <= tot_d; best_q <= best_d;
    fdiv_q <= fdiv_d;
  end

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.ready |=> req.ready) else $error("no return to idle");
  a_excl_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !(rsp.data.stats_valid && rsp.data.agg_valid))
    else $error("both valid flags set");
  a_hist_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_we |-> state_q == StSWrite) else $error("stray history write");
  a_minmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.data.stats_valid |-> rsp.data.area_min <= rsp.data.area_max)
    else $error("min above max");
endmodule

@@ tb/probe_window_area_aggregator_tb.sv @@
// testbench for the probe window area aggregator: directed table, then random beats
// depends on pwaa_pkg, pwaa_req_if, pwaa_rsp_if and the probe_window_area_aggregator rtl
module probe_window_area_aggregator_tb;
  localparam int unsigned Depth = pwaa_pkg::HistoryDepthDef;
  localparam int unsigned WatchLimit = 20000;

  typedef struct {
    pwaa_pkg::req_t req;
    logic known;
    pwaa_pkg::rsp_t rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pwaa_pkg::CfgIdxW-1:0] cfg_idx_i = pwaa_pkg::RegAggMode;
  logic [31:0] cfg_wdata_i = '0;

  pwaa_req_if req_ch ();
  pwaa_rsp_if rsp_ch ();

  probe_window_area_aggregator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic        mode_q;
  logic [31:0] map_q;
  logic signed [31:0] hist_q [8][4][Depth];
  int unsigned cnt_q [8][4];
  int unsigned head_q [8][4];
  logic signed [31:0] lo_q [8][4];
  logic signed [31:0] hi_q [8][4];
  logic        seen_q [8][4];

  pwaa_pkg::rsp_t expected_rsps [$];
  row_t rows_q [$];
  int unsigned fail_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 52;
  logic timed_out = 1'b0;

  function automatic logic [3:0] area_of(input int unsigned p);
    logic [3:0] a;
    a = map_q[p*4 +: 4];
    return (a == pwaa_pkg::NoArea || a >= 8) ? pwaa_pkg::NoArea : a;
  endfunction

  function automatic pwaa_pkg::rsp_t area_stats_step(input pwaa_pkg::req_t r);
    pwaa_pkg::rsp_t o;
    int unsigned p, m, w, used, pos, n;
    logic [3:0] a;
    longint sum, mean, total, best;
    o = '0;
    p = r.probe_index;
    m = r.metric_index;
    if (r.req_type == pwaa_pkg::ReqSample) begin
      hist_q[p][m][head_q[p][m]] = r.sample_value;
      head_q[p][m] = (head_q[p][m] + 1 >= Depth) ? 0 : head_q[p][m] + 1;
      if (cnt_q[p][m] < Depth) cnt_q[p][m]++;
      a = area_of(p);
      if (a != pwaa_pkg::NoArea) begin
        if (!seen_q[a[2:0]][m]) begin
          lo_q[a[2:0]][m] = r.sample_value;
          hi_q[a[2:0]][m] = r.sample_value;
          seen_q[a[2:0]][m] = 1'b1;
        end else begin
          if (r.sample_value < lo_q[a[2:0]][m]) lo_q[a[2:0]][m] = r.sample_value;
          if (r.sample_value > hi_q[a[2:0]][m]) hi_q[a[2:0]][m] = r.sample_value;
        end
        o.area_min = lo_q[a[2:0]][m];
        o.area_max = hi_q[a[2:0]][m];
        o.stats_valid = 1'b1;
      end
    end else begin
      w = r.window_len;
      if (w < 1) w = 1;
      if (w > Depth) w = Depth;
      n = 0;
      total = 0;
      best = 0;
      for (int unsigned q = 0; q < 8; q++) begin
        if (area_of(q) != {1'b0, r.area_index}) continue;
        used = cnt_q[q][m] > w ? w : cnt_q[q][m];
        if (used == 0) continue;
        pos = head_q[q][m];
        sum = 0;
        for (int unsigned i = 0; i < used; i++) begin
          pos = (pos == 0) ? Depth - 1 : pos - 1;
          sum += longint'(hist_q[q][m][pos]);
        end
        mean = sum / longint'(used);
        if (n == 0 || mean > best) best = mean;
        total += mean;
        n++;
      end
      if (n > 0) begin
        o.agg_value = mode_q ? 32'(best) : 32'(total / longint'(n));
        o.agg_valid = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic void add_row(input pwaa_pkg::req_t r, input logic known,
                                  input pwaa_pkg::rsp_t o);
    row_t row;
    row = '{r, known, o};
    rows_q.insert(rows_q.size(), row);
  endfunction

  task automatic send_beat(input pwaa_pkg::req_t r, input logic known,
                           input pwaa_pkg::rsp_t typed);
    pwaa_pkg::rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    p = area_stats_step(r);
    if (known && p != typed) begin
      fail_cnt++;
      if (fail_cnt <= 10) $display("table row disagrees with predictor: %p vs %p", typed, p);
    end
    expected_rsps.insert(expected_rsps.size(), p);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic send_rows();
    foreach (rows_q[i]) send_beat(rows_q[i].req, rows_q[i].known, rows_q[i].rsp);
    rows_q.delete();
  endtask

  task automatic drain_and_wait();
    req_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pwaa_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == pwaa_pkg::RegAggMode) mode_q = val[0];
    else map_q = val;
    @(posedge clk_i);
  endtask

  function automatic pwaa_pkg::req_t sample_of(int p, int m, logic signed [31:0] v);
    pwaa_pkg::req_t r;
    r = '0;
    r.req_type = pwaa_pkg::ReqSample;
    r.probe_index = 3'(p);
    r.metric_index = 2'(m);
    r.sample_value = v;
    r.area_index = 3'($urandom);
    r.window_len = 4'($urandom);
    return r;
  endfunction

  function automatic pwaa_pkg::req_t query_of(int a, int m, int w);
    pwaa_pkg::req_t r;
    r = '0;
    r.req_type = pwaa_pkg::ReqQuery;
    r.area_index = 3'(a);
    r.metric_index = 2'(m);
    r.window_len = 4'(w);
    r.probe_index = 3'($urandom);
    r.sample_value = $urandom;
    return r;
  endfunction

  function automatic pwaa_pkg::req_t random_req();
    pwaa_pkg::req_t r;
    r = $urandom_range(99) < 60 ? sample_of($urandom, $urandom, $urandom)
                                : query_of($urandom, $urandom, $urandom);
    if (r.req_type == pwaa_pkg::ReqSample && $urandom_range(3) == 0)
      r.sample_value = $urandom_range(1) ? 32'sh7fff_ff00 + $urandom_range(255)
                                         : 32'sh8000_0000 + $urandom_range(255);
    return r;
  endfunction

  function automatic pwaa_pkg::rsp_t stats(logic signed [31:0] lo, logic signed [31:0] hi);
    pwaa_pkg::rsp_t o;
    o = '0;
    o.area_min = lo;
    o.area_max = hi;
    o.stats_valid = 1'b1;
    return o;
  endfunction

  initial begin
    pwaa_pkg::rsp_t none;
    logic [31:0] maps [4];
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    none = '0;
    mode_q = 1'b0;
    map_q = 32'hffff_ffff;
    foreach (cnt_q[p, m]) begin
      cnt_q[p][m] = 0;
      head_q[p][m] = 0;
    end
    foreach (seen_q[a, m]) seen_q[a][m] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unassigned probes after reset, empty areas
    add_row(query_of(0, 0, 5), 1'b1, none);
    add_row(sample_of(7, 3, 32'sh7fff_ffff), 1'b1, none);
    add_row(query_of(7, 3, 0), 1'b1, none);
    send_rows();
    drain_and_wait();

    // probes 0..3 in area 0, 4..5 in area 7, 6 in area 9 (none), 7 unassigned
    write_reg(pwaa_pkg::RegAreaMap, 32'hf977_0000);
    add_row(sample_of(0, 1, 32'sh8000_0000), 1'b1,
            stats(32'sh8000_0000, 32'sh8000_0000));
    add_row(sample_of(1, 1, 32'sh7fff_ffff), 1'b1,
            stats(32'sh8000_0000, 32'sh7fff_ffff));
    add_row(sample_of(6, 1, 32'sh0000_0100), 1'b1, none);
    add_row(sample_of(4, 2, -32'sd5), 1'b1, stats(-32'sd5, -32'sd5));
    add_row(sample_of(5, 2, 32'sd3), 1'b1, stats(-32'sd5, 32'sd3));
    add_row(query_of(7, 2, 1), 1'b0, none);
    add_row(query_of(0, 1, 15), 1'b0, none);
    for (int i = 0; i < 12; i++) add_row(sample_of(2, 0, i * 77 - 300), 1'b0, none);
    add_row(query_of(0, 0, 0), 1'b0, none);
    add_row(query_of(0, 0, 10), 1'b0, none);
    add_row(query_of(0, 0, 11), 1'b0, none);
    add_row(query_of(1, 0, 4), 1'b1, none);
    send_rows();
    drain_and_wait();
    write_reg(pwaa_pkg::RegAggMode, 32'd1);
    send_beat(query_of(0, 1, 15), 1'b0, none);
    send_beat(query_of(7, 2, 2), 1'b0, none);
    drain_and_wait();

    maps[0] = 32'h0000_0000;
    maps[1] = 32'h7654_3210;
    maps[2] = 32'h3311_2200;
    maps[3] = 32'hffff_ffff;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 52;
        recv_idle_pct = 31;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(pwaa_pkg::RegAggMode, {31'd0, ph[0]});
      write_reg(pwaa_pkg::RegAreaMap, ph == 5 ? $urandom : maps[2'($urandom_range(2))]);
      for (int i = 0; i < 140; i++) send_beat(random_req(), 1'b0, none);
      drain_and_wait();
    end
    write_reg(pwaa_pkg::RegAreaMap, maps[3]);
    for (int i = 0; i < 10; i++) send_beat(random_req(), 1'b0, none);
    drain_and_wait();

    if (fail_cnt == 0 && !timed_out) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // receiver and checker
  always @(posedge clk_i) begin
    pwaa_pkg::rsp_t want;
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected beat %p", rsp_ch.data);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_ch.data.area_min !== want.area_min || rsp_ch.data.area_max !== want.area_max ||
            rsp_ch.data.stats_valid !== want.stats_valid ||
            rsp_ch.data.agg_value !== want.agg_value ||
            rsp_ch.data.agg_valid !== want.agg_valid) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("mismatch: expected %p got %p", want, rsp_ch.data);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      timed_out = 1'b1;
      $display("status: fail");
      $finish;
    end
  end
endmodule
